// ===== hdl/br1_pkg.sv =====
// ----------------------------------------------------------------------------
// br1_pkg
// Shared types and constants of the byte run row decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package br1_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RowW     = 16;

  localparam logic [CfgIdxW-1:0] CFG_ROW_LENGTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_RAW_MODE   = 1'b1;

  localparam logic [RowW-1:0] ROW_LENGTH_RESET = 16'd40;
  localparam logic [7:0]      HDR_SKIP         = 8'd128;

  // One decoded result as it travels through the queue.
  typedef struct packed {
    logic [7:0] out_value;
    logic [7:0] run_length;
    logic       row_done;
    logic       clipped;
  } res_t;

endpackage : br1_pkg

`default_nettype wire

// ===== hdl/br1_front.sv =====
// ----------------------------------------------------------------------------
// br1_front
// Accepts stream bytes, tracks header/literal/repeat phase and row position,
// and forms one result record per data byte.
// ----------------------------------------------------------------------------
`default_nettype none

module br1_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [br1_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [br1_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  input  wire logic [7:0]                   in_byte_i,
  input  wire logic                         space_i,
  output logic                              in_ready_o,
  output logic                              push_o,
  output br1_pkg::res_t                     res_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [6:0]                 lit_left_q, lit_left_d;
  logic [br1_pkg::RowW-1:0]   row_left_q, row_left_d;
  logic [br1_pkg::RowW-1:0]   row_length_q, row_length_d;
  logic                       raw_mode_q, raw_mode_d;
  logic [br1_pkg::RowW-1:0]   reload;
  logic [br1_pkg::RowW-1:0]   run_n;
  logic                       row_end;
  logic                       in_fire;

  assign in_ready_o = space_i;
  assign in_fire    = in_valid_i && space_i;
  assign reload     = (row_length_q == '0) ? br1_pkg::RowW'(1) : row_length_q;
  assign row_end    = (row_left_q <= br1_pkg::RowW'(1));
  assign run_n      = br1_pkg::RowW'(lit_left_q) + br1_pkg::RowW'(1);

  always_comb begin
    phase_d      = phase_q;
    lit_left_d   = lit_left_q;
    row_left_d   = row_left_q;
    row_length_d = row_length_q;
    raw_mode_d   = raw_mode_q;
    push_o       = 1'b0;
    res_o        = '0;

    if (in_fire) begin
      res_o.out_value  = in_byte_i;
      res_o.run_length = 8'd1;
      if (raw_mode_q) begin
        push_o         = 1'b1;
        res_o.row_done = row_end;
        row_left_d     = row_end ? reload : row_left_q - br1_pkg::RowW'(1);
      end else begin
        case (phase_q)
          PH_LITERAL: begin
            push_o         = 1'b1;
            res_o.row_done = row_end;
            if (row_end) begin
              res_o.clipped = (lit_left_q != '0);
              row_left_d    = reload;
              phase_d       = PH_HEADER;
              lit_left_d    = '0;
            end else begin
              row_left_d = row_left_q - br1_pkg::RowW'(1);
              if (lit_left_q == '0) begin
                phase_d = PH_HEADER;
              end else begin
                lit_left_d = lit_left_q - 7'd1;
              end
            end
          end
          PH_REPEAT: begin
            push_o = 1'b1;
            // The run ends the row once it reaches the bytes owed; it is clipped only if it exceeds them.
            if (run_n >= row_left_q) begin
              res_o.run_length = row_left_q[7:0];
              res_o.clipped    = (run_n > row_left_q);
              res_o.row_done   = 1'b1;
              row_left_d       = reload;
            end else begin
              res_o.run_length = run_n[7:0];
              row_left_d       = row_left_q - run_n;
            end
            phase_d    = PH_HEADER;
            lit_left_d = '0;
          end
          default: begin
            if (in_byte_i < br1_pkg::HDR_SKIP) begin
              phase_d    = PH_LITERAL;
              lit_left_d = in_byte_i[6:0];
            end else if (in_byte_i > br1_pkg::HDR_SKIP) begin
              phase_d    = PH_REPEAT;
              lit_left_d = 7'(8'd0 - in_byte_i);
            end else begin
              phase_d    = PH_HEADER;
              lit_left_d = '0;
            end
          end
        endcase
      end
    end

    if (cfg_we_i) begin
      case (cfg_index_i)
        br1_pkg::CFG_ROW_LENGTH: begin
          row_length_d = cfg_wdata_i;
          row_left_d   = (cfg_wdata_i == '0) ? br1_pkg::RowW'(1) : cfg_wdata_i;
          phase_d      = PH_HEADER;
          lit_left_d   = '0;
        end
        br1_pkg::CFG_RAW_MODE: begin
          raw_mode_d = cfg_wdata_i[0];
        end
        default: begin
          raw_mode_d = raw_mode_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      lit_left_q   <= '0;
      row_left_q   <= br1_pkg::ROW_LENGTH_RESET;
      row_length_q <= br1_pkg::ROW_LENGTH_RESET;
      raw_mode_q   <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      lit_left_q   <= lit_left_d;
      row_left_q   <= row_left_d;
      row_length_q <= row_length_d;
      raw_mode_q   <= raw_mode_d;
    end
  end

`ifndef SYNTHESIS
  a_row_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_left_q != '0)
    else $error("row position counter reached zero");

  a_clip_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.clipped |-> res_o.row_done)
    else $error("clipped result does not end the row");

  a_run_within_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (res_o.run_length != 8'd0) &&
               (br1_pkg::RowW'(res_o.run_length) <= row_left_q))
    else $error("result run exceeds bytes owed to the row");

  a_header_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !raw_mode_q && (phase_q == PH_HEADER) |-> !push_o)
    else $error("header byte produced a result");
`endif

endmodule : br1_front

`default_nettype wire

// ===== hdl/br1_queue.sv =====
// ----------------------------------------------------------------------------
// br1_queue
// Short register queue of result records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module br1_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire br1_pkg::res_t push_data_i,
  input  wire logic          pop_i,
  output logic               space_o,
  output logic               avail_o,
  output br1_pkg::res_t      head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  br1_pkg::res_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign space_o = (count_q != CntW'(DEPTH));
  assign avail_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && space_o;
  assign do_pop  = pop_i && avail_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o)
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count out of range");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not follow a push");
`endif

endmodule : br1_queue

`default_nettype wire

// ===== hdl/br1_back.sv =====
// ----------------------------------------------------------------------------
// br1_back
// Output stage: takes result records from the queue and holds each on the
// output ports until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module br1_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          avail_i,
  input  wire br1_pkg::res_t head_i,
  output logic               pop_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         out_value_o,
  output logic [7:0]         run_length_o,
  output logic               row_done_o,
  output logic               clipped_o
);

  logic          valid_q;
  br1_pkg::res_t data_q;

  // The stage reloads whenever it is empty or its current result leaves.
  assign pop_o = avail_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_value_o  = data_q.out_value;
  assign run_length_o = data_q.run_length;
  assign row_done_o   = data_q.row_done;
  assign clipped_o    = data_q.clipped;

`ifndef SYNTHESIS
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(data_q))
    else $error("output stage changed while stalled");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> avail_i && (!valid_q || out_ready_i))
    else $error("queue popped without room in output stage");

  a_nonzero_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> data_q.run_length != 8'd0)
    else $error("output result has zero run length");
`endif

endmodule : br1_back

`default_nettype wire

// ===== hdl/byterun1_row_decoder_core.sv =====
// ----------------------------------------------------------------------------
// byterun1_row_decoder_core
// Byte run (PackBits) row decoder with independent input and output sides.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_byte_i) takes one compressed byte
//   per transaction. Header bytes produce nothing; each literal byte yields
//   one result of run length 1; a repeat value byte yields one result with
//   its run length. Results leave on out_valid_o/out_ready_i.
//   Throughput is one byte per cycle while the queue has space: the front
//   decoder updates phase and row position for each accepted byte. A result
//   is written into the queue when its byte is accepted and then moves to
//   the output register once that register is empty or its result leaves.
//   The two-entry queue lets the front keep taking bytes while a result
//   waits; when the receiver stalls, the queue fills and in_ready_o drops
//   until the output register drains.
//   Configuration writes (cfg_we_i) take effect at once; write only while
//   the block is idle. Writing row_length restarts the row and the header
//   phase; raw_mode passes bytes through while still counting the row.
//   Reset clears the queue and output stage, sets row_length to 40 and
//   selects decoding mode.
// ----------------------------------------------------------------------------
`default_nettype none

module byterun1_row_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [br1_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [br1_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [7:0]                   in_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [7:0]                        out_value_o,
  output logic [7:0]                        run_length_o,
  output logic                              row_done_o,
  output logic                              clipped_o
);

  br1_pkg::res_t push_data, head;
  logic          push, space, avail, pop;

  br1_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .space_i     (space),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .res_o       (push_data)
  );

  br1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .space_o     (space),
    .avail_o     (avail),
    .head_o      (head)
  );

  br1_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (avail),
    .head_i       (head),
    .pop_o        (pop),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_value_o  (out_value_o),
    .run_length_o (run_length_o),
    .row_done_o   (row_done_o),
    .clipped_o    (clipped_o)
  );

endmodule : byterun1_row_decoder_core

`default_nettype wire
